FILE: hw/rtl/ilir_pkg.sv
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and constants for the indexed list with insert and remove.
// ----------------------------------------------------------------------------
package ilir_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int ITEM_WIDTH_DEF = 32;

    // fixed field widths of the channel words
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 6;
    localparam int ITEM_W  = 32;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 3'd0,
        CMD_PREPEND = 3'd1,
        CMD_READ    = 3'd2,
        CMD_WRITE   = 3'd3,
        CMD_REMOVE  = 3'd4,
        CMD_POP     = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

endpackage

FILE: hw/rtl/ilir_if.sv
// ----------------------------------------------------------------------------
// ilir_in_if / ilir_out_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface ilir_in_if
    import ilir_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  index;
    logic [ITEM_W-1:0] item;

    modport source (output valid, output command, output index, output item, input ready);
    modport sink   (input valid, input command, input index, input item, output ready);
endinterface

interface ilir_out_if
    import ilir_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic [STAT_W-1:0]  status;

    modport source (output valid, output value, output count, output status, input ready);
    modport sink   (input valid, input value, input count, input status, output ready);
endinterface

FILE: hw/rtl/indexed_list_insert_remove.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Bounded ordered list held in a one-write/one-read memory. A small
// sequencer with one address counter moves elements for prepend and remove.
//
//   channel  dir  words                      handshake
//   i_in     in   command, index, item       valid/ready
//   o_out    out  value, count, status       valid/ready, output register
//
// Append, write, errors and unused codes finish on acceptance; read, pop,
// remove and a prepend to a non-empty list pass through the sequencer.
// Each moved element is one read and one write on the single port pair.
// Reset clears the fill count, sequencer and output valid; memory needs none.
// A stalled result holds the output register; a new word is taken once it
// drains, and a finishing command waits for the free slot.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ilir_in_if.sink     i_in,
    ilir_out_if.source  o_out
);

    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CMP_W  = (FILL_W > IDX_W) ? FILL_W : IDX_W;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_LOAD     = 5'b00010,
        S_SHIFT_DN = 5'b00100,
        S_SHIFT_UP = 5'b01000,
        S_HEAD     = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [FILL_W-1:0]     r_fill, n_fill;
    logic [FILL_W-1:0]     r_ptr, n_ptr;
    logic [ITEM_WIDTH-1:0] r_value, n_value;
    logic [ITEM_WIDTH-1:0] r_item, n_item;
    logic                  r_remove, n_remove;

    logic [ITEM_WIDTH-1:0] r_mem [DEPTH];
    logic [ITEM_WIDTH-1:0] r_rdata;

    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_value;
    logic [COUNT_W-1:0]    r_out_count;
    t_status               r_out_status;

    logic                  w_we, w_re;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [ITEM_WIDTH-1:0] w_wdata;
    logic                  w_load;
    logic [ITEM_WIDTH-1:0] w_res_value;
    t_status               w_res_status;

    logic                  w_out_free, w_fire, w_full, w_empty, w_idx_ok;
    logic [FILL_W-1:0]     w_last, w_ptr_p1, w_ptr_p2, w_ptr_m1, w_ptr_m2;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_out_free;
    assign w_fire     = i_in.valid && i_in.ready;

    assign w_full   = (r_fill >= FILL_W'(DEPTH));
    assign w_empty  = (r_fill == '0);
    assign w_idx_ok = (CMP_W'(i_in.index) < CMP_W'(r_fill));
    assign w_last   = r_fill - FILL_W'(1);
    assign w_ptr_p1 = r_ptr + FILL_W'(1);
    assign w_ptr_p2 = r_ptr + FILL_W'(2);
    assign w_ptr_m1 = r_ptr - FILL_W'(1);
    assign w_ptr_m2 = r_ptr - FILL_W'(2);

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_ptr        = r_ptr;
        n_value      = r_value;
        n_item       = r_item;
        n_remove     = r_remove;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = '0;
        w_re         = 1'b0;
        w_raddr      = '0;
        w_load       = 1'b0;
        w_res_value  = '0;
        w_res_status = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    case (i_in.command)
                        CMD_APPEND: begin
                            w_load = 1'b1;
                            if (w_full) begin
                                w_res_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_fill[AW-1:0];
                                w_wdata = ITEM_WIDTH'(i_in.item);
                                n_fill  = r_fill + FILL_W'(1);
                            end
                        end
                        CMD_PREPEND: begin
                            if (w_full) begin
                                w_load       = 1'b1;
                                w_res_status = ST_FULL;
                            end else if (w_empty) begin
                                w_load  = 1'b1;
                                w_we    = 1'b1;
                                w_waddr = '0;
                                w_wdata = ITEM_WIDTH'(i_in.item);
                                n_fill  = FILL_W'(1);
                            end else begin
                                // walk from the tail down, one element a cycle
                                w_re    = 1'b1;
                                w_raddr = w_last[AW-1:0];
                                n_ptr   = r_fill;
                                n_item  = ITEM_WIDTH'(i_in.item);
                                n_state = S_SHIFT_UP;
                            end
                        end
                        CMD_READ: begin
                            if (w_idx_ok) begin
                                w_re     = 1'b1;
                                w_raddr  = AW'(i_in.index);
                                n_remove = 1'b0;
                                n_state  = S_LOAD;
                            end else begin
                                w_load       = 1'b1;
                                w_res_status = ST_RANGE;
                            end
                        end
                        CMD_WRITE: begin
                            w_load = 1'b1;
                            if (w_idx_ok) begin
                                w_we    = 1'b1;
                                w_waddr = AW'(i_in.index);
                                w_wdata = ITEM_WIDTH'(i_in.item);
                            end else begin
                                w_res_status = ST_RANGE;
                            end
                        end
                        CMD_REMOVE: begin
                            if (w_empty) begin
                                w_load       = 1'b1;
                                w_res_status = ST_EMPTY;
                            end else if (!w_idx_ok) begin
                                w_load       = 1'b1;
                                w_res_status = ST_RANGE;
                            end else begin
                                w_re     = 1'b1;
                                w_raddr  = AW'(i_in.index);
                                n_ptr    = FILL_W'(i_in.index);
                                n_remove = 1'b1;
                                n_state  = S_LOAD;
                            end
                        end
                        CMD_POP: begin
                            // a remove at the tail: nothing to shift
                            if (w_empty) begin
                                w_load       = 1'b1;
                                w_res_status = ST_EMPTY;
                            end else begin
                                w_re     = 1'b1;
                                w_raddr  = w_last[AW-1:0];
                                n_ptr    = w_last;
                                n_remove = 1'b1;
                                n_state  = S_LOAD;
                            end
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                if (r_remove && (w_ptr_p1 < r_fill)) begin
                    n_value = r_rdata;
                    w_re    = 1'b1;
                    w_raddr = w_ptr_p1[AW-1:0];
                    n_state = S_SHIFT_DN;
                end else if (w_out_free) begin
                    w_load      = 1'b1;
                    w_res_value = r_rdata;
                    n_fill      = r_remove ? w_last : r_fill;
                    n_state     = S_IDLE;
                end
            end
            S_SHIFT_DN: begin
                // rdata holds element ptr+1; it moves down to ptr
                if (w_ptr_p2 < r_fill) begin
                    w_we    = 1'b1;
                    w_waddr = r_ptr[AW-1:0];
                    w_wdata = r_rdata;
                    w_re    = 1'b1;
                    w_raddr = w_ptr_p2[AW-1:0];
                    n_ptr   = w_ptr_p1;
                end else if (w_out_free) begin
                    w_we        = 1'b1;
                    w_waddr     = r_ptr[AW-1:0];
                    w_wdata     = r_rdata;
                    w_load      = 1'b1;
                    w_res_value = r_value;
                    n_fill      = w_last;
                    n_state     = S_IDLE;
                end
            end
            S_SHIFT_UP: begin
                // rdata holds element ptr-1; it moves up to ptr
                w_we    = 1'b1;
                w_waddr = r_ptr[AW-1:0];
                w_wdata = r_rdata;
                if (r_ptr > FILL_W'(1)) begin
                    w_re    = 1'b1;
                    w_raddr = w_ptr_m2[AW-1:0];
                    n_ptr   = w_ptr_m1;
                end else begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (w_out_free) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    w_wdata = r_item;
                    w_load  = 1'b1;
                    n_fill  = r_fill + FILL_W'(1);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_value  <= n_value;
        r_item   <= n_item;
        r_remove <= n_remove;
        if (w_load) begin
            r_out_value  <= VALUE_W'(w_res_value);
            r_out_count  <= COUNT_W'(n_fill);
            r_out_status <= w_res_status;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.value  = r_out_value;
    assign o_out.count  = r_out_count;
    assign o_out.status = r_out_status;

endmodule

FILE: tb/ilir_list_checker.sv
// ----------------------------------------------------------------------------
// ilir_list_checker
// Watches the command and result channels of the indexed list. Every
// accepted command word is run through a local model of the list, and the
// expected result word is queued. Every accepted result word is compared
// field by field with the oldest queued expectation. Mismatches are counted.
// ----------------------------------------------------------------------------
module ilir_list_checker
    import ilir_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    ilir_in_if    i_cmd_ch,
    ilir_out_if   i_res_ch,
    output int    o_fail_count,
    output int    o_open_count
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        t_status            status;
    } t_list_result;

    logic [ITEM_W-1:0] cells [DEPTH_DEF];
    int                list_fill;
    t_list_result      expected_results [$];
    int                mismatches;
    int                open_words;

    assign o_fail_count = mismatches;
    assign o_open_count = open_words;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // remove the element at pos, close the gap, return it
    function automatic logic [ITEM_W-1:0] take_out(input int pos);
        logic [ITEM_W-1:0] v;
        int                i;
        v = cells[pos];
        for (i = pos; i + 1 < list_fill; i++)
            cells[i] = cells[i + 1];
        list_fill--;
        return v;
    endfunction

    function automatic t_list_result apply_command(
        input logic [CMD_W-1:0]  cmd,
        input logic [IDX_W-1:0]  idx,
        input logic [ITEM_W-1:0] val
    );
        t_list_result r;
        int           i;
        r.value  = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_APPEND: begin
                if (list_fill >= DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    cells[list_fill] = val;
                    list_fill++;
                end
            end
            CMD_PREPEND: begin
                if (list_fill >= DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_fill; i > 0; i--)
                        cells[i] = cells[i - 1];
                    cells[0] = val;
                    list_fill++;
                end
            end
            CMD_READ: begin
                if (idx >= list_fill) r.status = ST_RANGE;
                else                  r.value  = cells[idx];
            end
            CMD_WRITE: begin
                if (idx >= list_fill) r.status = ST_RANGE;
                else                  cells[idx] = val;
            end
            CMD_REMOVE: begin
                if (list_fill == 0)        r.status = ST_EMPTY;
                else if (idx >= list_fill) r.status = ST_RANGE;
                else                       r.value  = take_out(idx);
            end
            CMD_POP: begin
                if (list_fill == 0) r.status = ST_EMPTY;
                else                r.value  = take_out(list_fill - 1);
            end
            default: ; // unused codes leave the list alone
        endcase
        r.count = COUNT_W'(list_fill);
        return r;
    endfunction

    initial begin
        mismatches = 0;
        open_words = 0;
        list_fill  = 0;
    end

    always @(posedge i_clk) begin : watch
        t_list_result oldest;
        if (!i_rst_n) begin
            list_fill = 0;
            expected_results.delete();
        end else begin
            if (i_cmd_ch.valid && i_cmd_ch.ready)
                expected_results.push_back(
                    apply_command(i_cmd_ch.command, i_cmd_ch.index, i_cmd_ch.item));
            if (i_res_ch.valid && i_res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "result word with nothing expected: value %h count %0d status %0d",
                        i_res_ch.value, i_res_ch.count, i_res_ch.status));
                end else begin
                    oldest = expected_results.pop_front();
                    if (i_res_ch.value !== oldest.value)
                        report_mismatch($sformatf("value %h, expected %h",
                            i_res_ch.value, oldest.value));
                    if (i_res_ch.count !== oldest.count)
                        report_mismatch($sformatf("count %0d, expected %0d",
                            i_res_ch.count, oldest.count));
                    if (i_res_ch.status !== oldest.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                            i_res_ch.status, oldest.status));
                end
            end
        end
        open_words = expected_results.size();
    end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the indexed list testbench. Drives a directed opening sequence,
// then random command words in grow and shrink runs that reach both the
// full and the empty list, under four phases mixing command idling and result stalls.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import ilir_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
    localparam int               CYCLE_LIMIT   = 600000;
    localparam int               TAIL_CYCLES   = 80;
    localparam int               PHASE_WORDS   = 270;

    logic i_clk;
    logic i_rst_n;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    int   list_len  = 0;
    int   cycles    = 0;
    int   fail_count;
    int   open_count;

    ilir_in_if  cmd_ch ();
    ilir_out_if res_ch ();

    indexed_list_insert_remove i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    ilir_list_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_ch     (cmd_ch),
        .i_res_ch     (res_ch),
        .o_fail_count (fail_count),
        .o_open_count (open_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** indexed_list_insert_remove: FAILED **");
            $finish;
        end
    end

    // one command word; list_len follows the list so indexes can be aimed
    task automatic send_word(
        input logic [CMD_W-1:0]  cmd,
        input logic [IDX_W-1:0]  idx,
        input logic [ITEM_W-1:0] val
    );
        while ($urandom_range(99) < idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.index   <= idx;
        cmd_ch.item    <= val;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        case (cmd) inside
            CMD_APPEND, CMD_PREPEND: if (list_len < DEPTH_DEF) list_len++;
            CMD_REMOVE:              if (idx < list_len) list_len--;
            CMD_POP:                 if (list_len > 0) list_len--;
            default: ;
        endcase
    endtask

    // grow runs lean on inserts, shrink runs on removes; flip near the ends
    task automatic run_random(input int words);
        int                sent;
        bit                grow;
        int                pick;
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  idx;
        logic [ITEM_W-1:0] val;
        sent = 0;
        grow = (list_len < DEPTH_DEF / 2);
        while (sent < words) begin
            if (grow && list_len == DEPTH_DEF && $urandom_range(3) == 0)
                grow = 1'b0;
            else if (!grow && list_len == 0 && $urandom_range(3) == 0)
                grow = 1'b1;
            else if ($urandom_range(149) == 0)
                grow = !grow;

            pick = $urandom_range(99);
            if (grow) begin
                if      (pick < 40) cmd = CMD_APPEND;
                else if (pick < 70) cmd = CMD_PREPEND;
                else if (pick < 80) cmd = CMD_READ;
                else if (pick < 88) cmd = CMD_WRITE;
                else if (pick < 94) cmd = CMD_REMOVE;
                else if (pick < 98) cmd = CMD_POP;
                else                cmd = $urandom_range(1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
            end else begin
                if      (pick < 8)  cmd = CMD_APPEND;
                else if (pick < 14) cmd = CMD_PREPEND;
                else if (pick < 26) cmd = CMD_READ;
                else if (pick < 36) cmd = CMD_WRITE;
                else if (pick < 70) cmd = CMD_REMOVE;
                else if (pick < 98) cmd = CMD_POP;
                else                cmd = $urandom_range(1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
            end

            if ($urandom_range(99) < 85 && list_len > 0)
                idx = IDX_W'($urandom_range(list_len - 1));
            else
                idx = IDX_W'($urandom_range(63));

            pick = $urandom_range(9);
            val = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;

            send_word(cmd, idx, val);
            if (cmd != CMD_UNUSED_LO && cmd != CMD_UNUSED_HI)
                sent++;
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_APPEND;
        cmd_ch.index   <= '0;
        cmd_ch.item    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-list errors, unused codes, edge values, shifts
        send_word(CMD_POP,       6'd0,  '0);
        send_word(CMD_REMOVE,    6'd0,  '0);
        send_word(CMD_READ,      6'd0,  '0);
        send_word(CMD_WRITE,     6'd0,  32'h1234_5678);
        send_word(CMD_UNUSED_LO, 6'd21, 32'hDEAD_BEEF);
        send_word(CMD_UNUSED_HI, 6'd63, '1);
        send_word(CMD_APPEND,    6'd0,  '0);
        send_word(CMD_APPEND,    6'd63, '1);
        send_word(CMD_PREPEND,   6'd0,  32'hA5A5_A5A5);
        send_word(CMD_READ,      6'd0,  '0);
        send_word(CMD_READ,      6'd1,  '0);
        send_word(CMD_READ,      6'd2,  '0);
        send_word(CMD_READ,      6'd3,  '0);
        send_word(CMD_READ,      6'd63, '0);
        send_word(CMD_WRITE,     6'd1,  32'h5A5A_5A5A);
        send_word(CMD_WRITE,     6'd3,  '1);
        send_word(CMD_REMOVE,    6'd3,  '0);
        send_word(CMD_REMOVE,    6'd0,  '0);
        send_word(CMD_READ,      6'd0,  '0);
        send_word(CMD_REMOVE,    6'd1,  '0);
        send_word(CMD_POP,       6'd0,  '0);
        send_word(CMD_POP,       6'd0,  '0);

        run_random(PHASE_WORDS);
        idle_pct = 46; stall_pct = 0;
        run_random(PHASE_WORDS);
        idle_pct = 0;  stall_pct = 46;
        run_random(PHASE_WORDS);
        idle_pct = 21; stall_pct = 21;
        run_random(PHASE_WORDS);
        cmd_ch.valid <= 1'b0;

        repeat (2) @(posedge i_clk);
        while (open_count != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** indexed_list_insert_remove: PASSED **");
        end else begin
            $display("** indexed_list_insert_remove: FAILED **");
        end
        $finish;
    end

endmodule
